[design/cpvf_pkg.sv]
package cpvf_pkg;

	// Default fraction bits of the internal fixed-point format
	localparam int FRAC_BITS_DEF = 24;

	// Port formats
	localparam int IN_W     = 32;
	localparam int IN_FRAC  = 24;
	localparam int OUT_W    = 25;
	localparam int OUT_FRAC = 24;

	// Integer quotient bits: scaled components stay below 2, other quotients saturate at 16
	localparam int SCALE_IB = 1;
	localparam int SAT_IB   = 4;

	// Headroom above the binary point for internal signed values (magnitudes stay below 128)
	localparam int INT_W = 8;

	// Entries of the queue between the front and the back
	localparam int QUEUE_DEPTH = 4;

endpackage

[design/cube_plane_volume_fraction_unit.sv]
// The dividers are bit-per-stage, one quotient bit per pipeline stage.
// Throughput: one word per cycle in and out while the result side keeps ready high.
// Reset: arst_n clears every valid flag and the queue pointers asynchronously; datapath
//   registers are not reset and carry no meaning until their valid flag is set.
module cube_plane_volume_fraction_unit #(
	parameter int FRAC_BITS = cpvf_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [cpvf_pkg::IN_W-1:0] normal_x,
	input  logic signed [cpvf_pkg::IN_W-1:0] normal_y,
	input  logic signed [cpvf_pkg::IN_W-1:0] normal_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [cpvf_pkg::OUT_W-1:0]       volume_fraction
);

	// Queue word: whole-cube flag and the three sorted, scaled components
	localparam int CW = FRAC_BITS + 1;
	localparam int QW = 1 + 3 * CW;

	logic          f_valid, f_ready, f_whole;
	logic [CW-1:0] f_a, f_b, f_c;
	logic          b_valid, b_ready;
	logic [QW-1:0] q_word;

	// Front: take magnitudes, test for the whole cube, sort, scale by 1/gamma.
	// Stall only when its last stage holds a word the queue cannot take.
	cpvf_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.out_whole(f_whole),
		.out_a(f_a),
		.out_b(f_b),
		.out_c(f_c)
	);

	// Short queue: lets the front keep running while the back holds a stalled result
	cpvf_queue #(.W(QW)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(f_valid),
		.in_ready(f_ready),
		.in_data({f_whole, f_a, f_b, f_c}),
		.out_valid(b_valid),
		.out_ready(b_ready),
		.out_data(q_word)
	);

	// Back: polynomial pieces, branch quotients, final divide by 3C, clamp.
	// Its last stage is the output register.
	cpvf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(b_valid),
		.in_ready(b_ready),
		.whole(q_word[QW-1]),
		.a(q_word[3*CW-1:2*CW]),
		.b(q_word[2*CW-1:CW]),
		.c(q_word[CW-1:0]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.volume_fraction(volume_fraction)
	);

endmodule

[design/cpvf_qmul.sv]
module cpvf_qmul #(
	parameter int FRAC_BITS = cpvf_pkg::FRAC_BITS_DEF,
	parameter int W         = FRAC_BITS + cpvf_pkg::INT_W
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] p
);

	logic [W-1:0]   a_mag, b_mag, p_mag;
	logic [2*W-1:0] prod_q;
	logic           neg_q;

	assign a_mag = a[W-1] ? W'(-a) : W'(a);
	assign b_mag = b[W-1] ? W'(-b) : W'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= (2*W)'(a_mag) * (2*W)'(b_mag);
			neg_q  <= a[W-1] ^ b[W-1];
		end
	end

	// truncate the magnitude, then restore the sign
	assign p_mag = W'(prod_q >> FRAC_BITS);
	assign p     = neg_q ? -$signed(p_mag) : $signed(p_mag);

endmodule

[design/cpvf_qdiv.sv]
module cpvf_qdiv #(
	parameter int FRAC_BITS = cpvf_pkg::FRAC_BITS_DEF,
	parameter int NW        = 32,
	parameter int DW        = 32,
	parameter int IB        = cpvf_pkg::SAT_IB,
	parameter int TW        = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [NW-1:0]                num_mag,
	input  logic                         num_neg,
	input  logic [DW-1:0]                den,
	input  logic [TW-1:0]                tag_in,
	output logic                         out_valid,
	output logic signed [FRAC_BITS+IB+1:0] quot,
	output logic [TW-1:0]                tag_out
);

	localparam int QB = FRAC_BITS + IB;
	localparam int RW = ((NW + FRAC_BITS > DW + QB) ? NW + FRAC_BITS : DW + QB) + 1;

	logic [RW-1:0] rem_s  [0:QB];
	logic [QB-1:0] quo_s  [0:QB];
	logic [DW-1:0] den_s  [0:QB];
	logic [TW-1:0] tag_s  [0:QB];
	logic          sat_s  [0:QB];
	logic          zero_s [0:QB];
	logic          neg_s  [0:QB];
	logic          vld_s  [0:QB];

	logic [RW-1:0] num_ext;
	logic [QB:0]   mag_o;

	assign num_ext = RW'(num_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	// a zero divisor also lands here, since any numerator reaches zero
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num_ext << FRAC_BITS;
			quo_s[0]  <= '0;
			den_s[0]  <= den;
			tag_s[0]  <= tag_in;
			sat_s[0]  <= num_ext >= (RW'(den) << IB);
			zero_s[0] <= num_mag == '0;
			neg_s[0]  <= num_neg;
		end
	end

	for (genvar i = 1; i <= QB; i++) begin : g_stage
		logic [RW-1:0] den_sh;
		logic [RW:0]   diff;

		assign den_sh = RW'(den_s[i-1]) << (QB - i);
		assign diff   = {1'b0, rem_s[i-1]} - {1'b0, den_sh};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= diff[RW] ? rem_s[i-1] : diff[RW-1:0];
				quo_s[i]  <= diff[RW] ? quo_s[i-1] : (quo_s[i-1] | (QB'(1) << (QB - i)));
				den_s[i]  <= den_s[i-1];
				tag_s[i]  <= tag_s[i-1];
				sat_s[i]  <= sat_s[i-1];
				zero_s[i] <= zero_s[i-1];
				neg_s[i]  <= neg_s[i-1];
			end
		end
	end

	assign mag_o = zero_s[QB] ? '0 :
	               sat_s[QB]  ? {1'b1, {QB{1'b0}}} : {1'b0, quo_s[QB]};

	assign quot      = neg_s[QB] ? -$signed({1'b0, mag_o}) : $signed({1'b0, mag_o});
	assign out_valid = vld_s[QB];
	assign tag_out   = tag_s[QB];

endmodule

[design/cpvf_front.sv]
module cpvf_front #(
	parameter int FRAC_BITS = cpvf_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [cpvf_pkg::IN_W-1:0]      normal_x,
	input  logic signed [cpvf_pkg::IN_W-1:0]      normal_y,
	input  logic signed [cpvf_pkg::IN_W-1:0]      normal_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  out_whole,
	output logic [FRAC_BITS:0]                    out_a,
	output logic [FRAC_BITS:0]                    out_b,
	output logic [FRAC_BITS:0]                    out_c
);

	localparam int IW = cpvf_pkg::IN_W;
	localparam int SW = IW + 2;
	localparam int QB = FRAC_BITS + cpvf_pkg::SCALE_IB;
	localparam logic [SW-1:0] TWO_IN = SW'(2) << cpvf_pkg::IN_FRAC;

	logic          en;
	logic          v_s1, v_s2;
	logic [IW-1:0] rx_s1, ry_s1, rz_s1;
	logic [IW-1:0] r0_s2, r1_s2, r2_s2;
	logic [SW-1:0] den_s2;
	logic          whole_s2;

	logic [IW-1:0] p0, p1, q1, q2, m0, m1;
	logic [SW-1:0] sum;

	logic signed [QB+1:0] qa, qb, qc;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// magnitudes; the most negative input maps to 2^31
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= normal_x[IW-1] ? IW'(-normal_x) : IW'(normal_x);
			ry_s1 <= normal_y[IW-1] ? IW'(-normal_y) : IW'(normal_y);
			rz_s1 <= normal_z[IW-1] ? IW'(-normal_z) : IW'(normal_z);
		end
	end

	// three-compare sort network, ascending
	assign p0  = (rx_s1 > ry_s1) ? ry_s1 : rx_s1;
	assign p1  = (rx_s1 > ry_s1) ? rx_s1 : ry_s1;
	assign q1  = (p1 > rz_s1) ? rz_s1 : p1;
	assign q2  = (p1 > rz_s1) ? p1 : rz_s1;
	assign m0  = (p0 > q1) ? q1 : p0;
	assign m1  = (p0 > q1) ? p0 : q1;
	assign sum = SW'(rx_s1) + SW'(ry_s1) + SW'(rz_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			r0_s2    <= m0;
			r1_s2    <= m1;
			r2_s2    <= q2;
			den_s2   <= TWO_IN + sum;
			whole_s2 <= sum <= TWO_IN;
		end
	end

	// scale by 1/gamma: 2|v| / (2 + |x|+|y|+|z|)
	cpvf_qdiv #(
		.FRAC_BITS(FRAC_BITS), .NW(IW + 1), .DW(SW), .IB(cpvf_pkg::SCALE_IB), .TW(1)
	) u_div_a (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.num_mag({r0_s2, 1'b0}), .num_neg(1'b0), .den(den_s2), .tag_in(whole_s2),
		.out_valid(out_valid), .quot(qa), .tag_out(out_whole)
	);

	cpvf_qdiv #(
		.FRAC_BITS(FRAC_BITS), .NW(IW + 1), .DW(SW), .IB(cpvf_pkg::SCALE_IB), .TW(1)
	) u_div_b (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.num_mag({r1_s2, 1'b0}), .num_neg(1'b0), .den(den_s2), .tag_in(whole_s2),
		.out_valid(), .quot(qb), .tag_out()
	);

	cpvf_qdiv #(
		.FRAC_BITS(FRAC_BITS), .NW(IW + 1), .DW(SW), .IB(cpvf_pkg::SCALE_IB), .TW(1)
	) u_div_c (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.num_mag({r2_s2, 1'b0}), .num_neg(1'b0), .den(den_s2), .tag_in(whole_s2),
		.out_valid(), .quot(qc), .tag_out()
	);

	assign out_a = qa[FRAC_BITS:0];
	assign out_b = qb[FRAC_BITS:0];
	assign out_c = qc[FRAC_BITS:0];

endmodule

[design/cpvf_queue.sv]
module cpvf_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	localparam int DEPTH = cpvf_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	logic [W-1:0] mem_q [0:DEPTH-1];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          push, pop;

	assign in_ready  = cnt_q != (PW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

endmodule

[design/cpvf_back.sv]
module cpvf_back #(
	parameter int FRAC_BITS = cpvf_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             whole,
	input  logic [FRAC_BITS:0]               a,
	input  logic [FRAC_BITS:0]               b,
	input  logic [FRAC_BITS:0]               c,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [cpvf_pkg::OUT_W-1:0]       volume_fraction
);

	localparam int QW  = FRAC_BITS + cpvf_pkg::INT_W;
	localparam int CW  = FRAC_BITS + 1;
	localparam int DQW = FRAC_BITS + cpvf_pkg::SAT_IB + 2;
	localparam int OW  = cpvf_pkg::OUT_W;
	localparam int T1W = 2 + CW + QW;

	localparam logic signed [QW-1:0] ONE     = QW'(1) << FRAC_BITS;
	localparam logic signed [QW-1:0] THREE   = QW'(3) << FRAC_BITS;
	localparam logic signed [QW-1:0] ONEHALF = (QW'(3) << FRAC_BITS) >> 1;
	localparam logic [OW-1:0]        OUT_ONE = OW'(1) << cpvf_pkg::OUT_FRAC;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1
	logic [CW-1:0] a_s1, b_s1, c_s1;
	logic          whole_s1;
	logic signed [QW-1:0] ax, bx, cx, omb, omc, ombc, apb, apc;

	// stage 2
	logic [CW-1:0] a_s2, b_s2, c_s2;
	logic          whole_s2;
	logic signed [QW-1:0] omb_s2, omc_s2, ombc_s2;
	logic signed [QW-1:0] m_aa, m_ab, m_sb, m_sc, m_sbc, m_h1, m_h2;
	logic signed [QW-1:0] a2x, c2x, p2, ab2_2, base2, t2;

	// stage 3
	logic [CW-1:0] a_s3, b_s3, c_s3;
	logic          whole_s3;
	logic signed [QW-1:0] p_s3, ab2_s3, base_s3;
	logic signed [QW-1:0] m_ap, m_cb, m_cc, m_cbc, m_ct;
	logic signed [QW-1:0] a3x, b3x, c3x, num_a, num_2;
	logic signed [QW-1:0] n1, n2, add0;
	logic [QW-1:0]        d1, d2, n1_mag, n2_mag;
	logic                 a_ge, b_ge, ab_ge, c_ge, ac_ge, bc_lt, czero3;

	// divider outputs
	logic                 d1_valid;
	logic signed [DQW-1:0] q1, q2;
	logic [T1W-1:0]       t1_in, t1_out;

	// stage 4
	logic signed [QW-1:0] tmp_s4;
	logic [CW+1:0]        c3_s4;
	logic                 whole_s4, czero_s4;
	logic [QW-1:0]        tmp_mag;
	logic                 fd_valid;
	logic signed [DQW-1:0] vf;
	logic [1:0]           fd_tag;

	// stage 5
	logic [OW-1:0] res_s5, conv;
	logic [DQW-1:0] vf_u;

	assign en        = !v_s5 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= d1_valid;
			v_s5 <= fd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= a;
			b_s1     <= b;
			c_s1     <= c;
			whole_s1 <= whole;
		end
	end

	assign ax   = $signed(QW'(a_s1));
	assign bx   = $signed(QW'(b_s1));
	assign cx   = $signed(QW'(c_s1));
	assign omb  = ONE - bx;
	assign omc  = ONE - cx;
	assign ombc = ONE - bx - cx;
	assign apb  = ax + bx;
	assign apc  = ax + cx;

	cpvf_qmul #(.FRAC_BITS(FRAC_BITS), .W(QW)) u_aa  (.clk(clk), .en(en), .a(ax),      .b(ax),   .p(m_aa));
	cpvf_qmul #(.FRAC_BITS(FRAC_BITS), .W(QW)) u_ab  (.clk(clk), .en(en), .a(ax),      .b(bx),   .p(m_ab));
	cpvf_qmul #(.FRAC_BITS(FRAC_BITS), .W(QW)) u_sb  (.clk(clk), .en(en), .a(omb),     .b(omb),  .p(m_sb));
	cpvf_qmul #(.FRAC_BITS(FRAC_BITS), .W(QW)) u_sc  (.clk(clk), .en(en), .a(omc),     .b(omc),  .p(m_sc));
	cpvf_qmul #(.FRAC_BITS(FRAC_BITS), .W(QW)) u_sbc (.clk(clk), .en(en), .a(ombc),    .b(ombc), .p(m_sbc));
	cpvf_qmul #(.FRAC_BITS(FRAC_BITS), .W(QW)) u_h1  (.clk(clk), .en(en), .a(ONEHALF), .b(apb),  .p(m_h1));
	cpvf_qmul #(.FRAC_BITS(FRAC_BITS), .W(QW)) u_h2  (.clk(clk), .en(en), .a(ONEHALF), .b(apc),  .p(m_h2));

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			c_s2     <= c_s1;
			whole_s2 <= whole_s1;
			omb_s2   <= omb;
			omc_s2   <= omc;
			ombc_s2  <= ombc;
		end
	end

	assign a2x   = $signed(QW'(a_s2));
	assign c2x   = $signed(QW'(c_s2));
	assign p2    = THREE - ((a2x <<< 1) + a2x) + m_aa;
	assign ab2_2 = m_ab <<< 1;
	assign base2 = THREE - m_h1;
	assign t2    = THREE - m_h2;

	cpvf_qmul #(.FRAC_BITS(FRAC_BITS), .W(QW)) u_ap  (.clk(clk), .en(en), .a(a2x),   .b(p2),      .p(m_ap));
	cpvf_qmul #(.FRAC_BITS(FRAC_BITS), .W(QW)) u_cb  (.clk(clk), .en(en), .a(m_sb),  .b(omb_s2),  .p(m_cb));
	cpvf_qmul #(.FRAC_BITS(FRAC_BITS), .W(QW)) u_cc  (.clk(clk), .en(en), .a(m_sc),  .b(omc_s2),  .p(m_cc));
	cpvf_qmul #(.FRAC_BITS(FRAC_BITS), .W(QW)) u_cbc (.clk(clk), .en(en), .a(m_sbc), .b(ombc_s2), .p(m_cbc));
	cpvf_qmul #(.FRAC_BITS(FRAC_BITS), .W(QW)) u_ct  (.clk(clk), .en(en), .a(c2x),   .b(t2),      .p(m_ct));

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3     <= a_s2;
			b_s3     <= b_s2;
			c_s3     <= c_s2;
			whole_s3 <= whole_s2;
			p_s3     <= p2;
			ab2_s3   <= ab2_2;
			base_s3  <= base2;
		end
	end

	assign a3x    = $signed(QW'(a_s3));
	assign b3x    = $signed(QW'(b_s3));
	assign c3x    = $signed(QW'(c_s3));
	assign a_ge   = a3x >= ONE;
	assign b_ge   = b3x >= ONE;
	assign c_ge   = c3x >= ONE;
	assign ab_ge  = (a3x + b3x) >= ONE;
	assign ac_ge  = (a3x + c3x) >= ONE;
	assign bc_lt  = (b3x + c3x) < ONE;
	assign czero3 = c_s3 == '0;
	assign num_a  = m_ap - m_cb - (c_ge ? '0 : m_cc);
	assign num_2  = (m_ct <<< 1) - p_s3;

	// fold each branch into add0 + n1/d1 + n2/d2; a zero numerator gives zero
	always_comb begin
		add0 = '0;
		n1   = '0;
		d1   = QW'(ab2_s3);
		n2   = '0;
		d2   = QW'(ab2_s3);
		if (a_ge) begin
			n1 = ONE;
		end else if (b_ge) begin
			n1 = p_s3;
			d1 = QW'(b3x <<< 1);
		end else if (ab_ge) begin
			n1 = num_a;
		end else begin
			add0 = base_s3;
			if (c_ge) begin
				n1 = '0;
			end else if (ac_ge) begin
				n1 = -m_cc;
			end else begin
				n1 = num_2;
				d1 = QW'(b3x <<< 1);
				n2 = bc_lt ? m_cbc : '0;
			end
		end
	end

	assign n1_mag = n1[QW-1] ? QW'(-n1) : QW'(n1);
	assign n2_mag = n2[QW-1] ? QW'(-n2) : QW'(n2);
	assign t1_in  = {whole_s3, czero3, c_s3, add0};

	cpvf_qdiv #(
		.FRAC_BITS(FRAC_BITS), .NW(QW), .DW(QW), .IB(cpvf_pkg::SAT_IB), .TW(T1W)
	) u_div1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num_mag(n1_mag), .num_neg(n1[QW-1]), .den(d1), .tag_in(t1_in),
		.out_valid(d1_valid), .quot(q1), .tag_out(t1_out)
	);

	cpvf_qdiv #(
		.FRAC_BITS(FRAC_BITS), .NW(QW), .DW(QW), .IB(cpvf_pkg::SAT_IB), .TW(1)
	) u_div2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num_mag(n2_mag), .num_neg(n2[QW-1]), .den(d2), .tag_in(1'b0),
		.out_valid(), .quot(q2), .tag_out()
	);

	always_ff @(posedge clk) begin
		if (en) begin
			tmp_s4   <= $signed(t1_out[QW-1:0]) + QW'(q1) + QW'(q2);
			c3_s4    <= (CW+2)'(t1_out[QW+CW-1:QW]) * (CW+2)'(3);
			czero_s4 <= t1_out[QW+CW];
			whole_s4 <= t1_out[QW+CW+1];
		end
	end

	assign tmp_mag = tmp_s4[QW-1] ? QW'(-tmp_s4) : QW'(tmp_s4);

	cpvf_qdiv #(
		.FRAC_BITS(FRAC_BITS), .NW(QW), .DW(QW), .IB(cpvf_pkg::SAT_IB), .TW(2)
	) u_div_f (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.num_mag(tmp_mag), .num_neg(tmp_s4[QW-1]), .den(QW'(c3_s4)),
		.tag_in({whole_s4, czero_s4}),
		.out_valid(fd_valid), .quot(vf), .tag_out(fd_tag)
	);

	assign vf_u = vf;

	if (FRAC_BITS >= cpvf_pkg::OUT_FRAC) begin : g_narrow
		assign conv = OW'(vf_u >> (FRAC_BITS - cpvf_pkg::OUT_FRAC));
	end else begin : g_widen
		assign conv = OW'(vf_u) << (cpvf_pkg::OUT_FRAC - FRAC_BITS);
	end

	// clamp to [0,1]; whole cube and zero largest component override
	always_ff @(posedge clk) begin
		if (en) begin
			if (fd_tag[1]) begin
				res_s5 <= OUT_ONE;
			end else if (fd_tag[0] || vf <= 0) begin
				res_s5 <= '0;
			end else if (vf >= DQW'(ONE)) begin
				res_s5 <= OUT_ONE;
			end else begin
				res_s5 <= conv;
			end
		end
	end

	assign volume_fraction = res_s5;

endmodule

[design/cpvf_checker.sv]
module cpvf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [cpvf_pkg::OUT_W-1:0]       volume_fraction
);

	localparam logic [cpvf_pkg::OUT_W-1:0] OUT_ONE = cpvf_pkg::OUT_W'(1) << cpvf_pkg::OUT_FRAC;

	// result never exceeds one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> volume_fraction <= OUT_ONE)
		else $error("volume_fraction above one");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(volume_fraction))
		else $error("stalled result changed");

	// result-side ready frees the queue, so the input side opens in the following cycle
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |=> in_ready)
		else $error("input blocked after output drained");

	// nothing comes out at the first edge after reset
	a_rst: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind cube_plane_volume_fraction_unit cpvf_checker u_cpvf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.volume_fraction(volume_fraction)
);

[tb/cube_plane_volume_fraction_checker.sv]
module cube_plane_volume_fraction_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic signed [cpvf_pkg::IN_W-1:0] normal_x,
	input  logic signed [cpvf_pkg::IN_W-1:0] normal_y,
	input  logic signed [cpvf_pkg::IN_W-1:0] normal_z,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [cpvf_pkg::OUT_W-1:0]       volume_fraction,
	output int                               fail_count,
	output int                               pending
);
	localparam int FB = cpvf_pkg::FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) <<< FB;
	localparam longint SAT = longint'(16) <<< FB;

	logic [cpvf_pkg::OUT_W-1:0] fraction_q[$];

	function automatic logic [63:0] umag(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint qmul(longint a, longint b);
		logic [127:0] p;
		longint r;
		p = umag(a) * umag(b);
		r = longint'(p[FB +: 64]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint qdiv(longint num, longint den);
		logic [127:0] un;
		longint r;
		un = 128'(umag(num));
		if (un == 0)
			return 0;
		if (den <= 0 || un / 128'(den) >= 16)
			r = SAT;
		else
			r = longint'((un << FB) / 128'(den));
		return (num < 0) ? -r : r;
	endfunction

	function automatic longint qcube(longint v);
		return qmul(qmul(v, v), v);
	endfunction

	// Fraction of the centered cube on the origin side of plane n.r = 1
	function automatic logic [cpvf_pkg::OUT_W-1:0] cube_fraction(
		logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
		longint m[3];
		longint t, s, den, a, b, c, p, ab2, num, acc, vf;
		m[0] = longint'(umag(longint'(x)));
		m[1] = longint'(umag(longint'(y)));
		m[2] = longint'(umag(longint'(z)));
		s = m[0] + m[1] + m[2];
		if (s <= (longint'(2) <<< cpvf_pkg::IN_FRAC))
			return 25'(1) << cpvf_pkg::OUT_FRAC;
		if (m[0] > m[1]) begin t = m[0]; m[0] = m[1]; m[1] = t; end
		if (m[1] > m[2]) begin t = m[1]; m[1] = m[2]; m[2] = t; end
		if (m[0] > m[1]) begin t = m[0]; m[0] = m[1]; m[1] = t; end
		den = (longint'(2) <<< cpvf_pkg::IN_FRAC) + s;
		a = qdiv(2 * m[0], den);
		b = qdiv(2 * m[1], den);
		c = qdiv(2 * m[2], den);
		p = 3 * ONE - 3 * a + qmul(a, a);
		ab2 = 2 * qmul(a, b);
		if (a >= ONE) begin
			acc = qdiv(ONE, ab2);
		end else if (b >= ONE) begin
			acc = qdiv(p, 2 * b);
		end else if (a + b >= ONE) begin
			num = qmul(a, p) - qcube(ONE - b);
			if (c < ONE)
				num -= qcube(ONE - c);
			acc = qdiv(num, ab2);
		end else begin
			acc = 3 * ONE - qmul(ONE + ONE / 2, a + b);
			if (c >= ONE) begin
			end else if (a + c >= ONE) begin
				acc -= qdiv(qcube(ONE - c), ab2);
			end else begin
				num = 2 * qmul(c, 3 * ONE - qmul(ONE + ONE / 2, a + c)) - p;
				acc += qdiv(num, 2 * b);
				if (b + c < ONE)
					acc += qdiv(qcube(ONE - b - c), ab2);
			end
		end
		if (c == 0)
			return '0;
		vf = qdiv(acc, 3 * c);
		if (vf <= 0)
			return '0;
		if (vf >= ONE)
			return 25'(1) << cpvf_pkg::OUT_FRAC;
		return 25'(vf >>> (FB - cpvf_pkg::OUT_FRAC));
	endfunction

	assign pending = fraction_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready)
				fraction_q.push_back(cube_fraction(normal_x, normal_y, normal_z));
			if (out_valid && out_ready) begin
				if (fraction_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected word: volume_fraction %0d", volume_fraction);
					fail_count <= fail_count + 1;
				end else begin
					if (volume_fraction !== fraction_q[0]) begin
						if (fail_count < 10)
							$display("volume_fraction: expected %0d actual %0d",
								fraction_q[0], volume_fraction);
						fail_count <= fail_count + 1;
					end
					void'(fraction_q.pop_front());
				end
			end
		end
	end
endmodule

[tb/cube_plane_volume_fraction_unit_test.sv]
module cube_plane_volume_fraction_unit_test;
	localparam int LIMIT = 400000;
	localparam int N_RANDOM = 1950;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic signed [cpvf_pkg::IN_W-1:0] normal_x = '0;
	logic signed [cpvf_pkg::IN_W-1:0] normal_y = '0;
	logic signed [cpvf_pkg::IN_W-1:0] normal_z = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic [cpvf_pkg::OUT_W-1:0]       volume_fraction;
	int                               fail_count;
	int                               pending;
	int                               cycle = 0;
	int                               burst_left = 0;

	always #5 clk = ~clk;

	cube_plane_volume_fraction_unit i_dut (
		.clk, .arst_n, .in_valid, .in_ready, .normal_x, .normal_y, .normal_z,
		.out_valid, .out_ready, .volume_fraction
	);

	cube_plane_volume_fraction_checker i_checker (
		.clk, .arst_n, .in_valid, .in_ready, .normal_x, .normal_y, .normal_z,
		.out_valid, .out_ready, .volume_fraction, .fail_count, .pending
	);

	// Hard stop: no correct run comes near this many cycles
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: switch in turn among always ready, coin flip and heavy stall
	always @(negedge clk) begin
		case ((cycle / 97) % 3)
			0:       out_ready <= 1'b1;
			1:       out_ready <= $urandom_range(0, 1);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Offer one word and hold it until accepted; valid stays high for a following word in the same burst
	task automatic put_word(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
		burst_left--;
		normal_x <= x;
		normal_y <= y;
		normal_z <= z;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Pick a component from a spread of magnitude classes, random sign
	function automatic logic [31:0] pick_component();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0:       v = $urandom;
			1:       v = $urandom_range(0, 32'h0400_0000);
			2:       v = $urandom_range(0, 32'h0200_0000);
			3:       v = $urandom_range(0, 255);
			4:       v = 0;
			5:       v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			6:       v = $urandom_range(32'h0100_0000, 32'h1000_0000);
			default: v = $urandom_range(0, 32'h0100_0000);
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// zero normal, whole cube boundary at |x|+|y|+|z| = 2
		put_word(0, 0, 0);
		put_word(32'h0200_0000, 0, 0);
		put_word(32'h0200_0001, 0, 0);
		put_word(0, -32'sh0100_0000, 32'h0100_0000);
		put_word(0, 32'h0100_0000, 32'h0100_0001);
		// extremes, most negative value
		put_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		put_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		put_word(32'h8000_0000, 0, 0);
		put_word(0, 0, 32'h7FFF_FFFF);
		put_word(-1, -1, 32'h8000_0000);
		// tiny minor components against a huge major one
		put_word(1, 1, 32'h7FFF_FFFF);
		put_word(0, 1, 32'h7FFF_FFFF);
		put_word(32'h7FFF_FFFF, 0, 3);
		// equal and near-equal components, various branches
		put_word(32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
		put_word(32'h0400_0000, 32'h0400_0000, 32'h0400_0000);
		put_word(32'h0080_0000, 32'h0180_0000, 32'h0300_0000);
		put_word(32'h0020_0000, 32'h0040_0000, 32'h0800_0000);
		put_word(-32'sh0300_0000, 32'h0300_0000, -32'sh0010_0000);
		put_word(32'h1000_0000, -32'sh0800_0000, 32'h0000_1000);
		put_word(32'h0180_0000, 0, 0);
		put_word(32'h0500_0000, 32'h0500_0000, 0);
		repeat (N_RANDOM)
			put_word(pick_component(), pick_component(), pick_component());
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
